FILE: sv/polyline_nearest_arclength_core_defines.svh
// Assertion macros for the polyline nearest-point core.
// Included by the top level; no other dependencies.
`ifndef POLYLINE_NEAREST_ARCLENGTH_CORE_DEFINES_SVH
`define POLYLINE_NEAREST_ARCLENGTH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PNA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PNA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PNA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PNA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/pna_pkg.sv
// Shared widths, codes, state and command types of the polyline nearest-point core.
// No dependencies; every module in the project imports this package.
package pna_pkg;

  // Coordinates carry 8 fractional bits; the arithmetic is scale free.
  localparam int COORD_WIDTH  = 24;
  localparam int LENGTH_WIDTH = 40;

  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int EX_W       = DIFF_W + 1;
  localparam int OPND_W     = COORD_WIDTH + 3;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int LSQ_W      = 2 * COORD_WIDTH + 2;
  localparam int LEN_W      = COORD_WIDTH + 1;
  localparam int QUOT_W     = COORD_WIDTH + 3;
  localparam int DVD_W      = LEN_W + QUOT_W;
  localparam int SQRT_STEPS = LSQ_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQRT_STEPS + 1);
  localparam int DV_CNT_W   = $clog2(QUOT_W + 1);
  localparam int DIST_W     = 64;
  localparam int SUM_W      = ((LENGTH_WIDTH > LEN_W) ? LENGTH_WIDTH : LEN_W) + 1;
  localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((LENGTH_WIDTH + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 1'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LSQ_A, ST_LSQ_B, ST_LSQ_C, ST_DOT_A, ST_DOT_B, ST_DOT_C, ST_DOT_D,
    ST_SQRT_WAIT, ST_DIV_AL, ST_SX_A, ST_SX_B, ST_SX_W, ST_SY_A, ST_SY_B, ST_SY_W,
    ST_DIST_A, ST_DIST_B, ST_DIST_C, ST_COMMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    M_DXDX, M_DYDY, M_DXWX, M_DYWY, M_DXAL, M_DYAL, M_EXEX, M_EYEY
  } mul_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

  typedef enum logic {DIV_DOT, DIV_PROD} div_src_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     lsq_ld;
    logic     sqrt_start;
    logic     dot_ld;
    div_src_t div_src;
    logic     div_start;
    logic     along_zero;
    logic     along_full;
    logic     along_div;
    logic     ox_ld;
    logic     oy_ld;
    logic     commit;
  } pna_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic sqrt_done;
    logic div_done;
    logic len_zero;
    logic dot_pos;
    logic dot_ge_lsq;
  } pna_status_t;

endpackage

FILE: sv/pna_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on pna_pkg.
module pna_sqrt import pna_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LSQ_W-1:0] radicand,
  output logic             busy,
  output logic [LEN_W-1:0] root
);

  localparam logic [LSQ_W-1:0] ONE_INIT = {2'b01, {(LSQ_W-2){1'b0}}};

  logic [LSQ_W-1:0]    op, res, bitv, trial, op_next, res_next;
  logic [SQ_CNT_W-1:0] cnt;
  logic                ge;

  always_comb begin
    trial    = res + bitv;
    ge       = (op >= trial);
    op_next  = ge ? (op - trial) : op;
    res_next = ge ? ((res >> 1) + bitv) : (res >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= SQ_CNT_W'(SQRT_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == SQ_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= radicand;
      res  <= '0;
      bitv <= ONE_INIT;
    end else if (busy) begin
      op   <= op_next;
      res  <= res_next;
      bitv <= bitv >> 2;
    end
  end

  assign root = res[LEN_W-1:0];

endmodule

FILE: sv/pna_div.sv
// Restoring divider, one quotient bit per cycle; the dividend's upper part
// must be below the divisor. Depends on pna_pkg.
module pna_div import pna_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  logic [LEN_W-1:0]    rem, dsr;
  logic [QUOT_W-1:0]   low;
  logic [LEN_W:0]      trial, diff;
  logic                ge;
  logic [DV_CNT_W-1:0] cnt;

  always_comb begin
    trial = {rem, low[QUOT_W-1]};
    ge    = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DV_CNT_W'(QUOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DVD_W-1:QUOT_W];
      low <= dividend[QUOT_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      low <= {low[QUOT_W-2:0], ge};
    end
  end

  assign quot = low;

endmodule

FILE: sv/pna_datapath.sv
// Datapath: vertex and query registers, shared multiplier and accumulator,
// square root and divider units, best-point bookkeeping and result register.
// Depends on pna_pkg, pna_sqrt and pna_div.
module pna_datapath import pna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pna_cmd_t                cmd,
  output pna_status_t             sts,
  input  logic [COORD_WIDTH-1:0]  in_x,
  input  logic [COORD_WIDTH-1:0]  in_y,
  input  logic                    in_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]  cfg_data,
  output logic [LENGTH_WIDTH-1:0] out_param,
  output logic                    out_sat
);

  logic signed [COORD_WIDTH-1:0] qx, qy, prev_x, prev_y;
  logic signed [DIFF_W-1:0]      dx, dy, wx, wy, ox, oy;
  logic signed [DIFF_W-1:0]      vx_e, vy_e, px_e, py_e, qx_e, qy_e, mag_dx, mag_dy, qs;
  logic signed [EX_W-1:0]        ex, ey;
  logic signed [OPND_W-1:0]      ma, mb;
  logic signed [PROD_W-1:0]      prod, acc, dot;
  logic [LSQ_W-1:0]              lsq;
  logic [LEN_W-1:0]              len, along;
  logic                          last_r, awaiting_first, sat_seen;
  logic [LENGTH_WIDTH-1:0]       running, best_param;
  logic [DIST_W-1:0]             best_dist, cand_dsq;
  logic                          sqrt_busy, div_busy;
  logic [QUOT_W-1:0]             quot;
  logic [DVD_W-1:0]              dividend;
  logic [SUM_W-1:0]              cand_sum, run_sum;
  logic                          cand_sat, run_sat;
  logic [LENGTH_WIDTH-1:0]       cand_v, run_v, best_param_n, run_n;
  logic [DIST_W-1:0]             best_dist_n;
  logic                          sat_n;

  // Signed extensions of the coordinates to the difference width.
  assign vx_e = {in_x[COORD_WIDTH-1], in_x};
  assign vy_e = {in_y[COORD_WIDTH-1], in_y};
  assign px_e = {prev_x[COORD_WIDTH-1], prev_x};
  assign py_e = {prev_y[COORD_WIDTH-1], prev_y};
  assign qx_e = {qx[COORD_WIDTH-1], qx};
  assign qy_e = {qy[COORD_WIDTH-1], qy};

  assign mag_dx = dx[DIFF_W-1] ? -dx : dx;
  assign mag_dy = dy[DIFF_W-1] ? -dy : dy;
  assign ex = {wx[DIFF_W-1], wx} - {ox[DIFF_W-1], ox};
  assign ey = {wy[DIFF_W-1], wy} - {oy[DIFF_W-1], oy};

  always_ff @(posedge clk) begin
    if (rst) begin
      qx <= '0;
      qy <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_X: qx <= cfg_data;
        REG_QUERY_Y: qy <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      M_DXDX: begin
        ma = {{(OPND_W-DIFF_W){dx[DIFF_W-1]}}, dx};
        mb = {{(OPND_W-DIFF_W){dx[DIFF_W-1]}}, dx};
      end
      M_DYDY: begin
        ma = {{(OPND_W-DIFF_W){dy[DIFF_W-1]}}, dy};
        mb = {{(OPND_W-DIFF_W){dy[DIFF_W-1]}}, dy};
      end
      M_DXWX: begin
        ma = {{(OPND_W-DIFF_W){dx[DIFF_W-1]}}, dx};
        mb = {{(OPND_W-DIFF_W){wx[DIFF_W-1]}}, wx};
      end
      M_DYWY: begin
        ma = {{(OPND_W-DIFF_W){dy[DIFF_W-1]}}, dy};
        mb = {{(OPND_W-DIFF_W){wy[DIFF_W-1]}}, wy};
      end
      M_DXAL: begin
        ma = {{(OPND_W-DIFF_W){1'b0}}, mag_dx};
        mb = {{(OPND_W-LEN_W){1'b0}}, along};
      end
      M_DYAL: begin
        ma = {{(OPND_W-DIFF_W){1'b0}}, mag_dy};
        mb = {{(OPND_W-LEN_W){1'b0}}, along};
      end
      M_EXEX: begin
        ma = {{(OPND_W-EX_W){ex[EX_W-1]}}, ex};
        mb = {{(OPND_W-EX_W){ex[EX_W-1]}}, ex};
      end
      M_EYEY: begin
        ma = {{(OPND_W-EX_W){ey[EX_W-1]}}, ey};
        mb = {{(OPND_W-EX_W){ey[EX_W-1]}}, ey};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase
    if (cmd.lsq_ld) begin
      lsq <= acc[LSQ_W-1:0];
    end
    if (cmd.dot_ld) begin
      dot <= acc;
    end
  end

  pna_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc[LSQ_W-1:0]),
    .busy     (sqrt_busy),
    .root     (len)
  );

  assign dividend = (cmd.div_src == DIV_DOT) ? dot[DVD_W-1:0] : prod[DVD_W-1:0];

  pna_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (len),
    .busy     (div_busy),
    .quot     (quot)
  );

  // The scaled offset never exceeds the magnitude of its component.
  assign qs = quot[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx     <= vx_e - px_e;
      dy     <= vy_e - py_e;
      wx     <= awaiting_first ? (qx_e - vx_e) : (qx_e - px_e);
      wy     <= awaiting_first ? (qy_e - vy_e) : (qy_e - py_e);
      ox     <= '0;
      oy     <= '0;
      along  <= '0;
      last_r <= in_last;
    end else if (cmd.along_zero) begin
      ox    <= '0;
      oy    <= '0;
      along <= '0;
    end else if (cmd.along_full) begin
      ox    <= dx;
      oy    <= dy;
      along <= len;
    end else if (cmd.along_div) begin
      along <= (quot > QUOT_W'(len)) ? len : quot[LEN_W-1:0];
    end else if (cmd.ox_ld) begin
      ox <= dx[DIFF_W-1] ? -qs : qs;
    end else if (cmd.oy_ld) begin
      oy <= dy[DIFF_W-1] ? -qs : qs;
    end
  end

  always_comb begin
    cand_dsq = {{(DIST_W-PROD_W){1'b0}}, acc};
    cand_sum = SUM_W'(running) + SUM_W'(along);
    cand_sat = cand_sum > SUM_W'(LENGTH_MAX);
    cand_v   = cand_sat ? LENGTH_MAX : cand_sum[LENGTH_WIDTH-1:0];
    run_sum  = SUM_W'(running) + SUM_W'(len);
    run_sat  = run_sum > SUM_W'(LENGTH_MAX);
    run_v    = run_sat ? LENGTH_MAX : run_sum[LENGTH_WIDTH-1:0];
    if (awaiting_first) begin
      best_dist_n  = cand_dsq;
      best_param_n = '0;
      run_n        = '0;
      sat_n        = 1'b0;
    end else begin
      best_dist_n  = best_dist;
      best_param_n = best_param;
      sat_n        = sat_seen | run_sat;
      run_n        = run_v;
      if (cand_dsq < best_dist) begin
        best_dist_n  = cand_dsq;
        best_param_n = cand_v;
        sat_n        = sat_n | cand_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x         <= '0;
      prev_y         <= '0;
      running        <= '0;
      best_dist      <= '0;
      best_param     <= '0;
      sat_seen       <= 1'b0;
      awaiting_first <= 1'b1;
    end else begin
      if (cmd.load) begin
        prev_x <= in_x;
        prev_y <= in_y;
      end
      if (cmd.commit) begin
        best_dist  <= best_dist_n;
        best_param <= best_param_n;
        if (last_r) begin
          running        <= '0;
          sat_seen       <= 1'b0;
          awaiting_first <= 1'b1;
        end else begin
          running        <= run_n;
          sat_seen       <= sat_n;
          awaiting_first <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && last_r) begin
      out_param <= best_param_n;
      out_sat   <= sat_n;
    end
  end

  always_comb begin
    sts.first      = awaiting_first;
    sts.last       = last_r;
    sts.sqrt_done  = ~sqrt_busy;
    sts.div_done   = ~div_busy;
    sts.len_zero   = (len == '0);
    sts.dot_pos    = (dot > 0);
    sts.dot_ge_lsq = (dot >= $signed({{(PROD_W-LSQ_W){1'b0}}, lsq}));
  end

endmodule

FILE: sv/pna_ctrl.sv
// Controller: sequences one vertex through the datapath and owns the
// result valid flag. Depends on pna_pkg.
module pna_ctrl import pna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  pna_status_t sts,
  output pna_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid, commit_ok;

  // A closing vertex may only commit once the result register is free.
  assign commit_ok = ~(sts.last & out_valid & ~m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = sts.first ? ST_DIST_A : ST_LSQ_A;
      ST_LSQ_A:     state_next = ST_LSQ_B;
      ST_LSQ_B:     state_next = ST_LSQ_C;
      ST_LSQ_C:     state_next = ST_DOT_A;
      ST_DOT_A:     state_next = ST_DOT_B;
      ST_DOT_B:     state_next = ST_DOT_C;
      ST_DOT_C:     state_next = ST_DOT_D;
      ST_DOT_D:     state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          if (sts.len_zero || !sts.dot_pos || sts.dot_ge_lsq) begin
            state_next = ST_DIST_A;
          end else begin
            state_next = ST_DIV_AL;
          end
        end
      end
      ST_DIV_AL:    if (sts.div_done) state_next = ST_SX_A;
      ST_SX_A:      state_next = ST_SX_B;
      ST_SX_B:      state_next = ST_SX_W;
      ST_SX_W:      if (sts.div_done) state_next = ST_SY_A;
      ST_SY_A:      state_next = ST_SY_B;
      ST_SY_B:      state_next = ST_SY_W;
      ST_SY_W:      if (sts.div_done) state_next = ST_DIST_A;
      ST_DIST_A:    state_next = ST_DIST_B;
      ST_DIST_B:    state_next = ST_DIST_C;
      ST_DIST_C:    state_next = ST_COMMIT;
      ST_COMMIT:    if (commit_ok) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = M_DXDX;
    cmd.acc_op  = ACC_HOLD;
    cmd.div_src = DIV_DOT;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_LSQ_A: cmd.mul_sel = M_DXDX;
      ST_LSQ_B: begin
        cmd.mul_sel = M_DYDY;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_LSQ_C: cmd.acc_op = ACC_ADD;
      ST_DOT_A: begin
        cmd.mul_sel    = M_DXWX;
        cmd.lsq_ld     = 1'b1;
        cmd.sqrt_start = 1'b1;
      end
      ST_DOT_B: begin
        cmd.mul_sel = M_DYWY;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_DOT_C: cmd.acc_op = ACC_ADD;
      ST_DOT_D: cmd.dot_ld = 1'b1;
      ST_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          if (sts.len_zero || !sts.dot_pos) begin
            cmd.along_zero = 1'b1;
          end else if (sts.dot_ge_lsq) begin
            cmd.along_full = 1'b1;
          end else begin
            cmd.div_src   = DIV_DOT;
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_DIV_AL: cmd.along_div = sts.div_done;
      ST_SX_A:   cmd.mul_sel = M_DXAL;
      ST_SX_B: begin
        cmd.div_src   = DIV_PROD;
        cmd.div_start = 1'b1;
      end
      ST_SX_W:   cmd.ox_ld = sts.div_done;
      ST_SY_A:   cmd.mul_sel = M_DYAL;
      ST_SY_B: begin
        cmd.div_src   = DIV_PROD;
        cmd.div_start = 1'b1;
      end
      ST_SY_W:   cmd.oy_ld = sts.div_done;
      ST_DIST_A: cmd.mul_sel = M_EXEX;
      ST_DIST_B: begin
        cmd.mul_sel = M_EYEY;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_DIST_C: cmd.acc_op = ACC_ADD;
      ST_COMMIT: cmd.commit = commit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit && sts.last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

endmodule

FILE: sv/polyline_nearest_arclength_core.sv
// Nearest point on a 2-D polyline, reported as arc length from the first vertex.
// Vertices enter on the slave stream, one item each, in order; tlast marks the
// closing vertex. The query point is set through the write port (index 0 is x,
// index 1 is y); write it only while the block is idle, which is not enforced here.
// Each vertex is worked on alone: s_tready is high only between vertices.
// A first vertex passes only through the distance and commit states. A
// segment whose nearest point is an end also runs the bit-serial square root
// of the squared length (25 steps). A projection inside the segment adds
// three 27-step divisions on the shared divider.
// The closing vertex loads the result register and raises m_tvalid; tdata
// holds the arc length (8 fractional bits), tuser the saturation flag.
// While the receiver stalls the result holds, further vertices are still
// taken, and only the next closing vertex waits for the register to free.
// Reset (synchronous, active high) clears the query to the origin and makes
// the next vertex the first of a polyline; no result is pending.
// Depends on pna_pkg, pna_ctrl, pna_datapath and the defines header.
`include "polyline_nearest_arclength_core_defines.svh"
module polyline_nearest_arclength_core import pna_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // vertex_x, vertex_y
  input  logic                   s_tlast,   // last_vertex
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // nearest_param
  output logic                   m_tuser,   // length_saturated
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  pna_cmd_t                cmd;
  pna_status_t             sts;
  logic [LENGTH_WIDTH-1:0] out_param;

  pna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pna_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_x      (s_tdata[COORD_WIDTH-1:0]),
    .in_y      (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_last   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_param (out_param),
    .out_sat   (m_tuser)
  );

  assign m_tdata = OUT_DATA_W'(out_param);

  `PNA_ASSERT_IMP(a_units_idle, clk, rst, s_tready, sts.sqrt_done && sts.div_done, "unit busy at accept")
  `PNA_ASSERT_NXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "second item taken")
  `PNA_ASSERT_NXT(a_result_shown, clk, rst, cmd.commit && sts.last, m_tvalid, "result not shown")
  `PNA_ASSERT_NXT(a_first_after_last, clk, rst, cmd.commit && sts.last, sts.first, "not rearmed")

endmodule

FILE: bench/polyline_nearest_arclength_core_tb.sv
// Testbench for polyline_nearest_arclength_core: streams polyline vertices and
// checks each arc-length result against a behavioral predictor. Depends on pna_pkg.
`timescale 1ns / 1ps
module polyline_nearest_arclength_core_tb;
  import pna_pkg::*;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic                          last;
  } vertex_t;

  typedef struct packed {
    logic [LENGTH_WIDTH-1:0] param;
    logic                    sat;
  } nearest_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_QUERY_X;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  polyline_nearest_arclength_core DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  vertex_t pending_vertices[$];
  nearest_t expected_nearest[$];
  int errors = 0;
  int watchdog = 0;
  bit timed_out = 0;

  // Predictor state.
  longint q_x = 0, q_y = 0, p_x = 0, p_y = 0;
  logic [LENGTH_WIDTH:0] run_len = 0;
  logic [63:0] best_dsq = 0;
  logic [LENGTH_WIDTH-1:0] best_pos = 0;
  bit first_pending = 1, sat_flag = 0;

  localparam logic [LENGTH_WIDTH-1:0] LEN_LIMIT = '1;

  function automatic logic [127:0] mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [127:0] norm_sq(longint a, longint b);
    return mag(a) * mag(a) + mag(b) * mag(b);
  endfunction

  function automatic logic [63:0] clip64(logic [127:0] v);
    return (v[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] r, c;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (n >= c * c) r = c;
    end
    return r;
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] length_add(logic [LENGTH_WIDTH:0] a,
                                                          logic [127:0] b);
    logic [127:0] s;
    s = a + b;
    if (s > LEN_LIMIT) begin
      sat_flag = 1;
      return LEN_LIMIT;
    end
    return s[LENGTH_WIDTH-1:0];
  endfunction

  function automatic longint scale_comp(longint d, logic [127:0] along, logic [127:0] len);
    logic [127:0] m;
    m = (mag(d) * along) / len;
    return (d < 0) ? -longint'(m) : longint'(m);
  endfunction

  task automatic predict_vertex(vertex_t v);
    longint vx, vy, dx, dy, wx, wy, ox, oy;
    logic [127:0] lsq, len, along, pos, neg, dot;
    logic [63:0] seg_dsq;
    nearest_t res_item;
    vx = v.vx;
    vy = v.vy;
    if (first_pending) begin
      best_dsq = clip64(norm_sq(q_x - vx, q_y - vy));
      best_pos = 0;
      run_len = 0;
      sat_flag = 0;
      first_pending = 0;
    end else begin
      dx = vx - p_x; dy = vy - p_y;
      wx = q_x - p_x; wy = q_y - p_y;
      lsq = norm_sq(dx, dy);
      len = isqrt(lsq);
      pos = 0; neg = 0; along = 0; ox = 0; oy = 0;
      if (dx != 0 && wx != 0) begin
        if ((dx < 0) == (wx < 0)) pos += mag(dx) * mag(wx);
        else neg += mag(dx) * mag(wx);
      end
      if (dy != 0 && wy != 0) begin
        if ((dy < 0) == (wy < 0)) pos += mag(dy) * mag(wy);
        else neg += mag(dy) * mag(wy);
      end
      if (len != 0 && neg < pos) begin
        dot = pos - neg;
        if (dot >= lsq) begin
          along = len; ox = dx; oy = dy;
        end else begin
          along = dot / len;
          if (along > len) along = len;
          ox = scale_comp(dx, along, len);
          oy = scale_comp(dy, along, len);
        end
      end
      seg_dsq = clip64(norm_sq(wx - ox, wy - oy));
      if (seg_dsq < best_dsq) begin
        best_pos = length_add(run_len, along);
        best_dsq = seg_dsq;
      end
      run_len = length_add(run_len, len);
    end
    p_x = vx;
    p_y = vy;
    if (v.last) begin
      res_item.param = best_pos;
      res_item.sat = sat_flag;
      expected_nearest = {expected_nearest, res_item};
      first_pending = 1;
      run_len = 0;
      sat_flag = 0;
    end
  endtask

  // Driver.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_vertex(vertex_t'({s_tdata[COORD_WIDTH-1:0],
                                  s_tdata[2*COORD_WIDTH-1:COORD_WIDTH], s_tlast}));
        send_gap = $urandom_range(0, 13);
      end
      if ((!s_tvalid || s_tready) && send_gap > 0) begin
        s_tvalid <= 0;
        send_gap--;
      end else if ((!s_tvalid || s_tready) && pending_vertices.size() > 0) begin
        vertex_t nv;
        nv = pending_vertices.pop_front();
        s_tvalid <= 1;
        s_tdata <= {nv.vy, nv.vx};
        s_tlast <= nv.last;
      end else if (s_tready) begin
        s_tvalid <= 0;
      end
    end
  end

  // Monitor.
  int stall = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_nearest.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result param=%0h sat=%0b", m_tdata, m_tuser);
        end else begin
          nearest_t e;
          e = expected_nearest.pop_front();
          if (m_tdata[LENGTH_WIDTH-1:0] !== e.param || m_tuser !== e.sat) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: param exp %0h got %0h, sat exp %0b got %0b",
                       e.param, m_tdata[LENGTH_WIDTH-1:0], e.sat, m_tuser);
          end
        end
        stall = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        m_tready <= 0;
        stall--;
      end else begin
        m_tready <= 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog = 0;
      else watchdog++;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_WIDTH-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_QUERY_X) q_x = longint'(signed'(val));
    else q_y = longint'(signed'(val));
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord(int mode);
    case (mode)
      0: return COORD_WIDTH'($urandom);
      1: return COORD_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
      2: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
      default: return COORD_WIDTH'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  task automatic queue_vertex(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y, bit l);
    vertex_t nv;
    nv.vx = x;
    nv.vy = y;
    nv.last = l;
    pending_vertices = {pending_vertices, nv};
  endtask

  task automatic wait_idle();
    while ((pending_vertices.size() > 0 || s_tvalid || expected_nearest.size() > 0)
           && !timed_out)
      @(posedge clk);
    // Let a vertex with no result finish inside the block.
    repeat (150) @(posedge clk);
  endtask

  initial begin
    int n, mode;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(REG_QUERY_X, 24'd256);
    write_reg(REG_QUERY_Y, 24'd512);
    // Directed: single vertex, zero-length segment, interior projection, ends.
    queue_vertex(24'd0, 24'd0, 1);
    queue_vertex(24'd100, 24'd100, 0);
    queue_vertex(24'd100, 24'd100, 1);
    queue_vertex(24'd0, 24'd0, 0);
    queue_vertex(24'd1024, 24'd0, 0);
    queue_vertex(24'd1024, 24'd1024, 1);
    queue_vertex(-24'd500, 24'd0, 0);
    queue_vertex(-24'd1000, 24'd0, 1);
    // Long zigzag between extreme corners; its arc length stays below saturation.
    for (int i = 0; i < 8; i++)
      queue_vertex((i % 2) ? 24'h7FFFFF : 24'h800000, (i % 2) ? 24'h800000 : 24'h7FFFFF, i == 7);
    wait_idle();
    write_reg(REG_QUERY_X, 24'h7FFFFF);
    write_reg(REG_QUERY_Y, 24'h800000);
    queue_vertex(24'h800000, 24'h7FFFFF, 0);
    queue_vertex(24'h7FFFFF, 24'h800000, 0);
    queue_vertex(24'h800000, 24'h800000, 1);
    wait_idle();
    write_reg(REG_QUERY_X, 24'h800000);
    write_reg(REG_QUERY_Y, 24'h7FFFFF);
    queue_vertex(24'h7FFFFF, 24'h7FFFFF, 0);
    queue_vertex(24'h800000, 24'h800000, 1);
    wait_idle();
    // Random polylines in phases with fresh query points.
    for (int ph = 0; ph < 12 && !timed_out; ph++) begin
      mode = ph % 4;
      write_reg(REG_QUERY_X, rand_coord(mode));
      write_reg(REG_QUERY_Y, rand_coord(mode));
      for (int k = 0; k < 140; k += n) begin
        n = $urandom_range(1, 8);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 9) == 0)
            queue_vertex(rand_coord($urandom_range(0, 3)), rand_coord(2), j == n - 1);
          else
            queue_vertex(rand_coord(mode), rand_coord(mode), j == n - 1);
        end
      end
      wait_idle();
    end
    if (!timed_out) begin
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (watchdog >= 20000) begin
        timed_out = 1;
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
+incdir+sv
sv/pna_pkg.sv
sv/pna_sqrt.sv
sv/pna_div.sv
sv/pna_datapath.sv
sv/pna_ctrl.sv
sv/polyline_nearest_arclength_core.sv
bench/polyline_nearest_arclength_core_tb.sv
